/* rtl/prvm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prvm_pkg
// shared types and constants of the piecewise rule value mapper
// ----------------------------------------------------------------------------
package prvm_pkg;

    localparam int VW = 16;
    localparam int SW = 24;

    typedef struct packed {
        logic                 operation;
        logic [3:0]           rule_slot;
        logic                 rule_enable;
        logic                 rule_kind;
        logic signed [VW-1:0] source_low;
        logic signed [VW-1:0] source_high;
        logic signed [VW-1:0] target_low;
        logic signed [VW-1:0] target_high;
        logic signed [SW-1:0] steepness;
        logic signed [VW-1:0] midpoint;
        logic signed [VW-1:0] value_in;
    } t_req;

    typedef struct packed {
        logic signed [VW-1:0] mapped_value;
        logic                 used_fallback;
        logic [3:0]           chosen_rule;
    } t_rsp;

    typedef enum logic [3:0] {
        ST_IDLE, ST_SCAN, ST_FETCH, ST_PREP, ST_EXP, ST_SLOAD, ST_SDIV,
        ST_SMUL, ST_LDIV, ST_ROUND, ST_OUT
    } t_state;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_MAP  = 1'b1;

    localparam int EXP_BITS = 21;
    localparam logic [29:0] EXP_TAB [EXP_BITS] = '{
        30'd1073725440, 30'd1073709056, 30'd1073676290, 30'd1073610760,
        30'd1073479712, 30'd1073217664, 30'd1072693760, 30'd1071646719,
        30'd1069555701, 30'd1065385899, 30'd1057095000, 30'd1040706261,
        30'd1008687096, 30'd947573834,  30'd836230973,  30'd651257337,
        30'd395007542,  30'd145315154,  30'd19666268,   30'd360200,
        30'd121
    };

endpackage

/* rtl/piecewise_rule_value_mapper.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// piecewise_rule_value_mapper
// maps a signed value through a table of linear and logistic rules
// ----------------------------------------------------------------------------
// One request at a time. A load request writes one rule entry in the cycle it
// is accepted, so loads can follow each other with no gap. A map request
// scans the rule memory one entry a cycle through the registered read port,
// rereads the winner (ST_FETCH), prepares the operands (ST_PREP), then runs
// either a linear interpolation through a 48-step restoring divider, or a
// logistic curve: a 21-step exponential sequence on one shared 31x31
// multiplier, a setup state for the weight division, a 48-step divider for
// the weight and a state that scales it by the span.
// A final state rounds and saturates. A matched linear rule with equal
// source bounds skips the divider. The next request is taken only once the
// response has been accepted and the block is back in ST_IDLE, so a waiting
// response holds off the next map. The fallback rule uses the linear path.
// Valid bits live in flip-flops and clear at reset; the rule fields need no
// reset.
module piecewise_rule_value_mapper #(
    parameter int RULE_DEPTH = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  prvm_pkg::t_req  i_req,
    output logic            o_valid,
    input  logic            i_stall,
    output prvm_pkg::t_rsp  o_rsp
);
    import prvm_pkg::*;

    localparam int AW = (RULE_DEPTH > 1) ? $clog2(RULE_DEPTH) : 1;
    localparam int DW = 48;   // divider width

    // rule memory: kind, steep, mid, source low/high, target low/high
    typedef struct packed {
        logic                 kind;
        logic signed [SW-1:0] steep;
        logic signed [VW-1:0] mid;
        logic signed [VW-1:0] slo;
        logic signed [VW-1:0] shi;
        logic signed [VW-1:0] tlo;
        logic signed [VW-1:0] thi;
    } t_rule;

    t_rule             mem [RULE_DEPTH];
    t_rule             r_rd;
    logic [RULE_DEPTH-1:0] r_vbit;

    t_state            r_state, n_state;
    logic [AW:0]       r_idx;
    logic              r_rd_ok;      // read data is a valid scan read of r_rd_tag
    logic [AW-1:0]     r_rd_tag;
    logic              r_found;
    logic [AW-1:0]     r_best;
    logic signed [VW-1:0] r_best_lo;
    logic signed [VW-1:0] r_x;

    // datapath registers
    logic signed [VW:0]   r_base;     // added whole part base (target low)
    logic [DW-1:0]        r_num;      // dividend / remainder work
    logic [DW-1:0]        r_den;
    logic [DW-1:0]        r_quo;
    logic [DW-1:0]        r_rem;
    logic                 r_neg;
    logic [5:0]           r_cnt;
    logic [EXP_BITS-1:0]  r_u;
    logic                 r_usat;
    logic                 r_zpos;
    logic [30:0]          r_e;
    logic [VW:0]          r_span_mag;
    logic                 r_span_neg;
    t_rsp                 r_rsp;
    logic                 r_ovalid;

    logic load_go, map_go, slot_ok;
    assign o_stall = (r_state != ST_IDLE);
    assign load_go = i_valid && !o_stall && (i_req.operation == OP_LOAD);
    assign map_go  = i_valid && !o_stall && (i_req.operation == OP_MAP);
    assign slot_ok = (int'(i_req.rule_slot) < RULE_DEPTH);

    // memory port: write on load, read at rd_addr
    logic [AW-1:0] rd_addr;
    always_comb begin
        rd_addr = r_idx[AW-1:0];
        if (r_state == ST_FETCH) begin
            rd_addr = r_best;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_go && slot_ok) begin
            mem[AW'(i_req.rule_slot)] <= '{i_req.rule_kind, i_req.steepness,
                i_req.midpoint, i_req.source_low, i_req.source_high,
                i_req.target_low, i_req.target_high};
        end
        r_rd     <= mem[rd_addr];
        r_rd_tag <= rd_addr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vbit <= '0;
        end else if (load_go && slot_ok) begin
            r_vbit[AW'(i_req.rule_slot)] <= i_req.rule_enable;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    logic div_done, exp_done;
    assign div_done = (r_cnt == 6'(DW - 1));
    assign exp_done = (r_cnt == 6'(EXP_BITS - 1));
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (map_go) n_state = ST_SCAN;
            ST_SCAN:  if (r_idx == (AW+1)'(RULE_DEPTH)) n_state = ST_FETCH;
            ST_FETCH: n_state = ST_PREP;
            ST_PREP:  n_state = (r_found && r_rd.kind) ? ST_EXP : ST_LDIV;
            ST_EXP:   if (exp_done) n_state = ST_SLOAD;
            ST_SLOAD: n_state = ST_SDIV;
            ST_SDIV:  if (div_done) n_state = ST_SMUL;
            ST_SMUL:  n_state = ST_ROUND;
            ST_LDIV:  if (div_done || r_den == '0) n_state = ST_ROUND;
            ST_ROUND: n_state = ST_OUT;
            ST_OUT:   if (!r_ovalid) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // scan candidate from the previous read
    logic cand;
    assign cand = r_rd_ok && r_vbit[r_rd_tag] && (r_x >= r_rd.slo) && (r_x <= r_rd.shi);

    // one shared 31x31 multiplier for the exponential and the weight scaling
    logic [30:0] mul_a, mul_b;
    logic [61:0] mul_p;
    always_comb begin
        mul_a = r_e;
        mul_b = {1'b0, EXP_TAB[r_cnt[4:0]]};
        if (r_state == ST_SMUL) begin
            mul_a = {14'd0, r_span_mag};
            mul_b = r_quo[30:0];
        end
    end
    assign mul_p = mul_a * mul_b;

    // exponential step for the current bit of |z|
    logic [30:0] e_next;
    assign e_next = r_u[r_cnt[4:0]] ? 31'((mul_p + 62'(1 << 29)) >> 30) : r_e;

    // restoring divider step
    logic [DW:0] trial;
    logic [DW-1:0] rem_sh;
    assign rem_sh = {r_rem[DW-2:0], r_num[DW-1]};
    assign trial  = {1'b0, rem_sh} - {1'b0, r_den};

    // rounding of base + signed(q, r)/d, half away from zero
    logic signed [DW+1:0] q_s, whole;
    logic [DW:0] r_adj;
    logic up;
    logic signed [DW+1:0] res_full;
    always_comb begin
        q_s   = $signed({2'b00, r_quo});
        r_adj = {1'b0, r_rem};
        if (r_neg) begin
            q_s = -q_s;
            if (r_rem != '0) begin
                q_s   = q_s - 1;
                r_adj = {1'b0, r_den} - {1'b0, r_rem};
            end
        end
        whole = q_s + (DW+2)'(r_base);
        if (whole >= 0) up = ({r_adj, 1'b0} >= {2'b00, r_den});
        else            up = ({r_adj, 1'b0} >  {2'b00, r_den});
        res_full = whole + $signed({{(DW+1){1'b0}}, up});
        if (r_den == '0) res_full = (DW+2)'(r_base);
    end

    // prep values from the fetched rule or the fallback rule
    logic signed [VW+1:0] dx, ds, span;
    logic signed [VW+SW+1:0] z;
    logic [VW+SW+1:0] zmag;
    always_comb begin
        if (r_found) begin
            dx   = (VW+2)'(r_x) - (VW+2)'(r_rd.slo);
            ds   = (VW+2)'(r_rd.shi) - (VW+2)'(r_rd.slo);
            span = (VW+2)'(r_rd.thi) - (VW+2)'(r_rd.tlo);
        end else begin
            dx   = (VW+2)'(r_x) + 18'sd1000;
            ds   = 18'sd2001;
            span = 18'sd200;
        end
        z    = (VW+SW+2)'(r_rd.steep) * ((VW+SW+2)'(r_x) - (VW+SW+2)'(r_rd.mid));
        zmag = z[VW+SW+1] ? (VW+SW+2)'(-z) : (VW+SW+2)'(z);
    end

    logic [VW+1:0] dxm, spm;
    assign dxm = dx[VW+1] ? (VW+2)'(-dx) : (VW+2)'(dx);
    assign spm = span[VW+1] ? (VW+2)'(-span) : (VW+2)'(span);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
            r_idx    <= '0;
            r_rd_ok  <= 1'b0;
            r_found  <= 1'b0;
        end else begin
            if (r_ovalid && !i_stall) r_ovalid <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (map_go) begin
                        r_x     <= i_req.value_in;
                        r_idx   <= '0;
                        r_rd_ok <= 1'b0;
                        r_found <= 1'b0;
                    end
                end
                ST_SCAN: begin
                    if (cand && (!r_found || r_rd.slo < r_best_lo)) begin
                        r_found   <= 1'b1;
                        r_best    <= r_rd_tag;
                        r_best_lo <= r_rd.slo;
                    end
                    r_rd_ok <= (r_idx < (AW+1)'(RULE_DEPTH));
                    r_idx   <= r_idx + 1'b1;
                end
                ST_FETCH: begin
                    r_rd_ok <= 1'b0;
                end
                ST_PREP: begin
                    r_base     <= r_found ? (VW+1)'(r_rd.tlo) : '0;
                    r_span_mag <= spm[VW:0];
                    r_span_neg <= span[VW+1];
                    r_cnt      <= '0;
                    r_rem      <= '0;
                    r_quo      <= '0;
                    r_u        <= zmag[EXP_BITS-1:0];
                    r_usat     <= (zmag >> EXP_BITS) != '0;
                    r_zpos     <= !z[VW+SW+1] && (z != '0);
                    r_e        <= 31'h4000_0000;
                    // linear setup
                    r_num <= DW'(dxm) * DW'(spm);
                    r_den <= (ds > 0) ? DW'(ds) : '0;
                    r_neg <= dx[VW+1] != span[VW+1];
                end
                ST_EXP: begin
                    // large |z| flushes the exponential to zero
                    if (exp_done) begin
                        r_e   <= r_usat ? '0 : e_next;
                        r_cnt <= '0;
                    end else begin
                        r_e   <= e_next;
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                ST_SLOAD: begin
                    // weight = (num * 2^16 + den/2) / den, den = 1 + e in Q30
                    r_den <= DW'(r_e) + DW'(31'h4000_0000);
                    r_num <= ((r_zpos ? DW'(31'h4000_0000) : DW'(r_e)) << 16)
                             + ((DW'(r_e) + DW'(31'h4000_0000)) >> 1);
                    r_rem <= '0;
                    r_quo <= '0;
                    r_cnt <= '0;
                end
                ST_SDIV: begin
                    if (!trial[DW]) begin
                        r_rem <= trial[DW-1:0];
                        r_quo <= {r_quo[DW-2:0], 1'b1};
                    end else begin
                        r_rem <= rem_sh;
                        r_quo <= {r_quo[DW-2:0], 1'b0};
                    end
                    r_num <= r_num << 1;
                    r_cnt <= div_done ? '0 : r_cnt + 1'b1;
                end
                ST_SMUL: begin
                    // span * weight / 2^16 split into whole and fraction
                    r_quo <= DW'(mul_p[61:16]);
                    r_rem <= DW'(mul_p[15:0]);
                    r_den <= DW'(32'h0001_0000);
                    r_neg <= r_span_neg;
                    r_cnt <= '0;
                end
                ST_LDIV: begin
                    if (r_den != '0) begin
                        if (!trial[DW]) begin
                            r_rem <= trial[DW-1:0];
                            r_quo <= {r_quo[DW-2:0], 1'b1};
                        end else begin
                            r_rem <= rem_sh;
                            r_quo <= {r_quo[DW-2:0], 1'b0};
                        end
                        r_num <= r_num << 1;
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                ST_ROUND: begin
                    if (res_full > (DW+2)'(32767))
                        r_rsp.mapped_value <= 16'sh7fff;
                    else if (res_full < -(DW+2)'(32768))
                        r_rsp.mapped_value <= 16'sh8000;
                    else
                        r_rsp.mapped_value <= res_full[VW-1:0];
                    r_rsp.used_fallback <= !r_found;
                    r_rsp.chosen_rule   <= r_found ? 4'(r_best) : 4'd0;
                    r_ovalid <= 1'b1;
                end
                ST_OUT: begin
                end
                default: begin
                end
            endcase
        end
    end

    assign o_valid = r_ovalid;
    assign o_rsp   = r_rsp;

`ifndef SYNTH
    a_no_out_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (r_state == ST_OUT || r_state == ST_IDLE))
        else $error("result out of place");
    a_fb_rule: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_rsp.used_fallback) |-> (o_rsp.chosen_rule == 4'd0))
        else $error("fallback rule index");
    a_stall_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        map_go |=> o_stall)
        else $error("accepted while busy");
`endif
endmodule

/* tb/tb_piecewise_rule_value_mapper.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_piecewise_rule_value_mapper
// self-checking regression of the rule value mapper: directed rule tables and
// random load/map streams, predicted in the bench and checked per response
// ----------------------------------------------------------------------------
module tb_piecewise_rule_value_mapper;
    import prvm_pkg::*;

    localparam int DEPTH      = 16;
    localparam int IDLE_LIMIT = 5000;   // cycles with no handshake at all
    localparam int DRAIN_CYC  = 300;    // longer than one logistic map
    localparam int REQ_W      = $bits(t_req);

    logic i_clk;
    logic i_rst_n;
    logic i_valid;
    logic o_stall;
    t_req i_req;
    logic o_valid;
    logic i_stall;
    t_rsp o_rsp;

    piecewise_rule_value_mapper #(.RULE_DEPTH(DEPTH)) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_req   (i_req),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_rsp   (o_rsp)
    );

    // bench copy of the rule table
    bit   rule_on [DEPTH];
    t_req rule_mem [DEPTH];

    t_rsp mapped_q [$];
    int   n_errors;
    int   send_idle_pct;
    int   recv_idle_pct;
    int   quiet_cycles;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------------
    function automatic longint unsigned mag(longint v);
        return (v < 0) ? longint'(-v) : longint'(v);
    endfunction

    // base + (+-m)/d, rounded half away from zero
    function automatic longint div_round(longint base, longint unsigned m, bit neg,
                                         longint unsigned d);
        longint unsigned q0, r0, r;
        longint q, whole;
        bit up;
        q0 = m / d;
        r0 = m % d;
        r  = r0;
        q  = longint'(q0);
        if (neg) begin
            q = -q;
            if (r0 != 0) begin
                q = q - 1;
                r = d - r0;
            end
        end
        whole = base + q;
        up = (whole >= 0) ? (2 * r >= d) : (2 * r > d);
        return whole + (up ? 1 : 0);
    endfunction

    function automatic longint interp_linear(longint x, longint sl, longint sh,
                                             longint tl, longint th);
        longint dx, span, ds;
        dx = x - sl;
        span = th - tl;
        ds = sh - sl;
        if (ds <= 0) return tl;
        return div_round(tl, mag(dx) * mag(span), (dx < 0) != (span < 0),
                         longint'(ds));
    endfunction

    function automatic longint interp_logistic(longint x, longint tl, longint th,
                                               longint k, longint mid);
        longint z, span;
        longint unsigned u, e, num, den, s;
        z = k * (x - mid);
        span = th - tl;
        u = mag(z);
        e = 64'd1 << 30;
        if (u >= (64'd1 << EXP_BITS)) begin
            e = 0;
        end else begin
            for (int i = 0; i < EXP_BITS; i++)
                if (u[i]) e = (e * longint'(EXP_TAB[i]) + (64'd1 << 29)) >> 30;
        end
        num = (z <= 0) ? e : (64'd1 << 30);
        den = (64'd1 << 30) + e;
        s = ((num << 16) + den / 2) / den;
        return div_round(tl, mag(span) * s, span < 0, 64'd65536);
    endfunction

    // apply one accepted request to the bench table, queue the mapped value
    task automatic predict_mapping(input t_req r);
        int win;
        longint x, v;
        t_rsp rsp;
        if (r.operation == OP_LOAD) begin
            rule_on[r.rule_slot]  = r.rule_enable;
            rule_mem[r.rule_slot] = r;
            return;
        end
        win = -1;
        x = r.value_in;
        for (int i = 0; i < DEPTH; i++) begin
            if (!rule_on[i] || x < rule_mem[i].source_low || x > rule_mem[i].source_high)
                continue;
            if (win < 0 || rule_mem[i].source_low < rule_mem[win].source_low) win = i;
        end
        if (win < 0)
            v = interp_linear(x, -1000, 1001, 0, 200);
        else if (rule_mem[win].rule_kind)
            v = interp_logistic(x, rule_mem[win].target_low, rule_mem[win].target_high,
                                rule_mem[win].steepness, rule_mem[win].midpoint);
        else
            v = interp_linear(x, rule_mem[win].source_low, rule_mem[win].source_high,
                              rule_mem[win].target_low, rule_mem[win].target_high);
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        rsp.mapped_value  = v[15:0];
        rsp.used_fallback = (win < 0);
        rsp.chosen_rule   = (win < 0) ? 4'd0 : 4'(win);
        mapped_q = {mapped_q, rsp};
    endtask

    // ------------------------------------------------------------------------
    // driving: every call starts at a falling edge and leaves valid high
    // ------------------------------------------------------------------------
    task automatic send_request(input t_req r);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_req   <= r;
        do @(posedge i_clk); while (o_stall);
        predict_mapping(r);
        @(negedge i_clk);
    endtask

    task automatic load_rule(input int slot, input bit en, input bit kind,
                             input int sl, input int sh, input int tl, input int th,
                             input int k, input int mid);
        t_req r;
        r = '0;
        r.operation   = OP_LOAD;
        r.rule_slot   = 4'(slot);
        r.rule_enable = en;
        r.rule_kind   = kind;
        r.source_low  = 16'(sl);
        r.source_high = 16'(sh);
        r.target_low  = 16'(tl);
        r.target_high = 16'(th);
        r.steepness   = 24'(k);
        r.midpoint    = 16'(mid);
        r.value_in    = 16'($urandom);
        send_request(r);
    endtask

    task automatic map_value(input int x);
        t_req r;
        r = t_req'(REQ_W'({$urandom, $urandom, $urandom, $urandom, $urandom}));
        r.operation = OP_MAP;
        r.value_in  = 16'(x);
        send_request(r);
    endtask

    // ------------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        n_errors++;
    endtask

    always @(negedge i_clk) i_stall <= ($urandom_range(0, 99) < recv_idle_pct);

    always @(posedge i_clk) begin
        t_rsp want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (mapped_q.size() == 0) begin
                report_mismatch("unexpected response", int'(o_rsp.mapped_value), 0);
            end else begin
                want = mapped_q.pop_front();
                if (o_rsp.mapped_value !== want.mapped_value)
                    report_mismatch("mapped_value", int'(o_rsp.mapped_value),
                                    int'(want.mapped_value));
                if (o_rsp.used_fallback !== want.used_fallback)
                    report_mismatch("used_fallback", int'(o_rsp.used_fallback),
                                    int'(want.used_fallback));
                if (o_rsp.chosen_rule !== want.chosen_rule)
                    report_mismatch("chosen_rule", int'(o_rsp.chosen_rule),
                                    int'(want.chosen_rule));
            end
        end
    end

    // watchdog on handshake silence
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || !i_rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("piecewise_rule_value_mapper regression: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    task automatic test_fallback;
        map_value(-32768);
        map_value(32767);
        map_value(0);
        map_value(-1000);
        map_value(1001);
    endtask

    task automatic test_linear;
        // full-scale target span, endpoints and a rounding point
        load_rule(0, 1, 0, -100, 100, -32768, 32767, 0, 0);
        map_value(-100);
        map_value(100);
        map_value(7);
        // degenerate interval gives target low
        load_rule(1, 1, 0, 200, 200, 123, -5, 0, 0);
        map_value(200);
        // descending target
        load_rule(5, 1, 0, 1000, 32767, 32767, -32768, 0, 0);
        map_value(32767);
        map_value(1001);
    endtask

    task automatic test_priority;
        // equal low bound, lower slot wins; a wider rule with a smaller low wins
        load_rule(2, 1, 0, 300, 400, 0, 100, 0, 0);
        load_rule(3, 1, 0, 300, 500, 0, 1000, 0, 0);
        map_value(350);
        load_rule(15, 1, 0, 250, 600, 5, 9, 0, 0);
        map_value(350);
        // inverted interval never matches
        load_rule(6, 1, 0, 20000, 10000, 1, 2, 0, 0);
        map_value(15000);
    endtask

    task automatic test_logistic;
        load_rule(4, 1, 1, -5000, -1000, -32768, 32767, 65536, -3000);
        map_value(-3000);
        map_value(-2990);
        map_value(-5000);
        load_rule(4, 1, 1, -5000, -1000, 100, -100, -8388608, -32768);
        map_value(-1000);
        load_rule(4, 1, 1, -5000, -1000, -7, 8, 0, 0);
        map_value(-1234);
        // disabling keeps fields but drops the match
        load_rule(4, 0, 1, -5000, -1000, 1, 2, 8388607, 32767);
        map_value(-3000);
    endtask

    task automatic test_random(input int n_items);
        int slot, lo, hi, w, k, pick;
        for (int n = 0; n < n_items; n++) begin
            if ($urandom_range(0, 99) < 30) begin
                slot = $urandom_range(0, DEPTH - 1);
                if ($urandom_range(0, 9) == 0) begin
                    // raw noise load
                    load_rule(slot, $urandom_range(0, 1), $urandom_range(0, 1),
                              $urandom, $urandom, $urandom, $urandom, $urandom,
                              $urandom);
                end else begin
                    lo = $urandom_range(0, 65535) - 32768;
                    w  = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 65535)
                                                     : $urandom_range(0, 3000);
                    hi = (lo + w > 32767) ? 32767 : lo + w;
                    k  = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 1 << 19) - (1 << 18)
                                                     : $urandom;
                    load_rule(slot, $urandom_range(0, 9) != 0, $urandom_range(0, 1), lo, hi,
                              $urandom, $urandom, k,
                              ($urandom_range(0, 1) == 0) ? lo + (w / 2) : $urandom);
                end
            end else begin
                pick = $urandom_range(0, DEPTH - 1);
                if ($urandom_range(0, 99) < 70 && rule_on[pick] &&
                    rule_mem[pick].source_low <= rule_mem[pick].source_high) begin
                    lo = rule_mem[pick].source_low;
                    hi = rule_mem[pick].source_high;
                    map_value(lo + $urandom_range(0, hi - lo));
                end else begin
                    map_value($urandom);
                end
            end
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_stall       = 1'b0;
        i_req         = '0;
        n_errors      = 0;
        quiet_cycles  = 0;
        send_idle_pct = 6;
        recv_idle_pct = 55;
        for (int i = 0; i < DEPTH; i++) begin
            rule_on[i]  = 1'b0;
            rule_mem[i] = '0;
        end
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_fallback();
        test_linear();
        test_priority();
        test_logistic();
        test_random(330);

        // swap idling sides, then run with no idling at all
        send_idle_pct = 55;
        recv_idle_pct = 6;
        test_random(330);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(340);

        i_valid <= 1'b0;
        wait (mapped_q.size() == 0);
        repeat (DRAIN_CYC) @(posedge i_clk);
        if (n_errors == 0 && mapped_q.size() == 0) begin
            $display("piecewise_rule_value_mapper regression: pass");
        end else begin
            $display("piecewise_rule_value_mapper regression: fail");
        end
        $finish;
    end

endmodule
